FILE: hdl/lzwd_pkg.sv
`default_nettype none
package lzwd_pkg;

	localparam logic [2:0] ST_BYTE     = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_ACCEPTED = 3'd2;
	localparam logic [2:0] ST_BUSY     = 3'd3;
	localparam logic [2:0] ST_ERROR    = 3'd4;

	localparam logic [4:0] START_WIDTH = 5'd9;
	localparam logic [16:0] CLEAR_CODE = 17'd256;
	localparam logic [16:0] FIRST_FREE = 17'd257;

	localparam logic [0:0] CMD_PUSH = 1'b0;
	localparam logic [0:0] CMD_PULL = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DATA,
		S_FIN,
		S_POP
	} state_t;

	typedef struct packed {
		logic        ready;
		logic [15:0] code;
	} unpack_out_t;

endpackage
`default_nettype wire

FILE: hdl/lzwd_ram.sv
`default_nettype none
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/lzwd_unpack.sv
`default_nettype none
module lzwd_unpack
	import lzwd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  in_byte,
	input  wire logic [4:0]  width,
	input  wire logic        commit,
	output unpack_out_t      res
);

	logic [23:0] buf_q;
	logic [4:0]  cnt_q;
	logic [23:0] merged;
	logic [4:0]  cnt8;
	logic [23:0] mask;

	// The byte lands above the bits still held, LSB first.
	assign merged = buf_q | (24'(in_byte) << cnt_q);
	assign cnt8 = cnt_q + 5'd8;
	assign mask = (24'd1 << width) - 24'd1;
	assign res.ready = cnt8 >= width;
	assign res.code = 16'(merged & mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
		end else if (commit) begin
			if (res.ready) begin
				buf_q <= merged >> width;
				cnt_q <= cnt8 - width;
			end else begin
				buf_q <= merged;
				cnt_q <= cnt8;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/lzw_variable_width_decoder_unit.sv
`default_nettype none
// LZW decoder for .Z-style code streams. Push beats (cmd 0) feed compressed
// bytes; a push that completes a code expands it into the output stack by
// walking the dictionary memory, one string byte per cycle, and answers when
// the walk is done, so such a push holds the input until its whole string
// is on the stack (for the KwKwK case the extra byte goes in with the push
// itself). Other pushes answer in the cycle after they are taken. Pull beats
// (cmd 1) pop one decoded byte each, through a pop state that waits on the
// registered read of the stack memory. Pushes are refused while decoded bytes
// are pending. The dictionary and the stack are memories of 2^MAX_CODE_BITS
// entries; no clearing pass is needed after reset.
module lzw_variable_width_decoder_unit
	import lzwd_pkg::*;
#(
	parameter int MAX_CODE_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  out_byte,
	output logic      [2:0]  status,
	output logic             last_of_string
);

	localparam int AW = MAX_CODE_BITS;
	localparam int DW = MAX_CODE_BITS + 1;
	localparam int SIZE = 1 << MAX_CODE_BITS;
	localparam int DICT_W = MAX_CODE_BITS + 8;

	state_t state_q, state_n;

	logic [4:0]    limit_q;
	logic [DW-1:0] depth_q;
	logic [4:0]    width_q;
	logic [DW-1:0] nfc_q;
	logic [AW-1:0] prev_code_q;
	logic          prev_valid_q;
	logic [7:0]    prev_first_q;
	logic          err_q;
	logic [AW-1:0] code_q;
	logic [AW-1:0] x_q;
	logic          last_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic [2:0]    status_q;
	logic          last_out_q;

	logic [4:0]  lim;
	logic        accept;
	logic        unp_commit;
	unpack_out_t unp;
	logic [16:0] c17;
	logic [16:0] nfc17;
	logic        is_clear;
	logic        is_bad;
	logic        is_kwk;
	logic [AW-1:0] x_start;
	logic        start_walk;

	logic        res_we;
	logic [7:0]  res_byte;
	logic [2:0]  res_status;
	logic        res_last;

	logic [AW-1:0]     dict_raddr;
	logic [DICT_W-1:0] dict_rdata;
	logic              dict_we;
	logic [AW-1:0]     dict_waddr;
	logic [DICT_W-1:0] dict_wdata;
	logic [AW-1:0]     dict_prefix;

	logic          stk_push;
	logic          stk_we;
	logic [7:0]    stk_wdata;
	logic [AW-1:0] stk_raddr;
	logic [7:0]    stk_rdata;

	logic          fin_add;
	logic [DW-1:0] nfc_after;
	logic          fin_grow;
	logic          cfg_we;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata = (paddr == 3'd0) ? 32'(limit_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 5'd12;
		end else if (cfg_we) begin
			limit_q <= pwdata[4:0];
		end
	end

	assign lim = (limit_q > 5'(MAX_CODE_BITS)) ? 5'(MAX_CODE_BITS)
		: ((limit_q < START_WIDTH) ? START_WIDTH : limit_q);

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;

	assign unp_commit = accept && (cmd == CMD_PUSH) && !err_q && (depth_q == '0);

	lzwd_unpack u_unpack (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (in_byte),
		.width   (width_q),
		.commit  (unp_commit),
		.res     (unp)
	);

	assign c17 = {1'b0, unp.code};
	assign nfc17 = 17'(nfc_q);
	assign is_clear = c17 == CLEAR_CODE;
	assign is_bad = (c17 > nfc17) || ((c17 == nfc17) && !prev_valid_q);
	assign is_kwk = c17 == nfc17;
	assign x_start = is_kwk ? prev_code_q : unp.code[AW-1:0];
	assign start_walk = unp_commit && unp.ready && !is_clear && !is_bad;

	assign dict_prefix = dict_rdata[DICT_W-1:8];

	// Growth of the dictionary and of the code width once a code is done.
	assign fin_add = prev_valid_q && ((nfc_q >> lim) == '0);
	assign nfc_after = fin_add ? nfc_q + DW'(1) : nfc_q;
	assign fin_grow = (width_q < lim) && ((nfc_after >> width_q) != '0);

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (cmd == CMD_PULL) && (depth_q != '0)) begin
					state_n = S_POP;
				end else if (start_walk) begin
					state_n = (x_start[AW-1:8] != '0) ? S_DATA : S_FIN;
				end
			end
			S_DATA: begin
				if (dict_prefix[AW-1:8] == '0) begin
					state_n = S_FIN;
				end
			end
			S_FIN: state_n = S_IDLE;
			S_POP: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// Datapath controls.
	always_comb begin
		res_we = 1'b0;
		res_byte = 8'd0;
		res_status = ST_ACCEPTED;
		res_last = 1'b0;
		stk_push = 1'b0;
		stk_wdata = prev_first_q;
		dict_raddr = x_start;
		dict_we = 1'b0;
		dict_waddr = nfc_q[AW-1:0];
		dict_wdata = {prev_code_q, x_q[7:0]};
		stk_raddr = AW'(depth_q - DW'(1));
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == CMD_PULL) begin
						if (depth_q == '0) begin
							res_we = 1'b1;
							res_status = err_q ? ST_ERROR : ST_EMPTY;
						end
					end else if (err_q) begin
						res_we = 1'b1;
						res_status = ST_ERROR;
					end else if (depth_q != '0) begin
						res_we = 1'b1;
						res_status = ST_BUSY;
					end else if (!unp.ready || is_clear) begin
						res_we = 1'b1;
						res_status = ST_ACCEPTED;
					end else if (is_bad) begin
						res_we = 1'b1;
						res_status = ST_ERROR;
					end else if (is_kwk) begin
						stk_push = 1'b1;
						stk_wdata = prev_first_q;
					end
				end
			end
			S_DATA: begin
				stk_push = 1'b1;
				stk_wdata = dict_rdata[7:0];
				dict_raddr = dict_prefix;
			end
			S_FIN: begin
				stk_push = 1'b1;
				stk_wdata = x_q[7:0];
				dict_we = fin_add;
				res_we = 1'b1;
				res_status = ST_ACCEPTED;
			end
			S_POP: begin
				res_we = 1'b1;
				res_status = ST_BYTE;
				res_byte = stk_rdata;
				res_last = last_q;
			end
			default: begin
				res_we = 1'b0;
			end
		endcase
	end

	// A full stack drops further bytes.
	assign stk_we = stk_push && !depth_q[DW-1];

	lzwd_ram #(
		.WIDTH (DICT_W),
		.DEPTH (SIZE)
	) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (dict_waddr),
		.wdata (dict_wdata),
		.raddr (dict_raddr),
		.rdata (dict_rdata)
	);

	lzwd_ram #(
		.WIDTH (8),
		.DEPTH (SIZE)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[AW-1:0]),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			width_q <= START_WIDTH;
			nfc_q <= DW'(FIRST_FREE);
			prev_code_q <= '0;
			prev_valid_q <= 1'b0;
			prev_first_q <= 8'd0;
			err_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (stk_we) begin
				depth_q <= depth_q + DW'(1);
			end
			if ((state_q == S_IDLE) && accept && (cmd == CMD_PULL) && (depth_q != '0)) begin
				depth_q <= depth_q - DW'(1);
				last_q <= depth_q == DW'(1);
			end
			if (unp_commit && unp.ready) begin
				if (is_clear) begin
					width_q <= START_WIDTH;
					nfc_q <= DW'(FIRST_FREE);
					prev_valid_q <= 1'b0;
				end else if (is_bad) begin
					err_q <= 1'b1;
				end
			end
			if (state_q == S_FIN) begin
				nfc_q <= nfc_after;
				if (fin_grow) begin
					width_q <= width_q + 5'd1;
				end
				prev_code_q <= code_q;
				prev_first_q <= x_q[7:0];
				prev_valid_q <= 1'b1;
			end
			if (res_we) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_walk) begin
			code_q <= unp.code[AW-1:0];
			x_q <= x_start;
		end else if ((state_q == S_DATA) && (dict_prefix[AW-1:8] == '0)) begin
			x_q <= dict_prefix;
		end
		if (res_we) begin
			out_byte_q <= res_byte;
			status_q <= res_status;
			last_out_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign status = status_q;
	assign last_of_string = last_out_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input taken while a code or pull is in progress");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(SIZE))
		else $error("stack depth beyond its memory");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (out_valid && (status == ST_ACCEPTED)))
		else $error("finished code gave no result");

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
	import lzwd_pkg::*;

	localparam int MAXB = 12;
	localparam int SZ = 1 << MAXB;
	localparam logic [2:0] LIMIT_ADDR = 3'd0;

	typedef struct packed {
		logic [7:0] ob;
		logic [2:0] st;
		logic       last;
	} beat_t;

	typedef struct {
		logic [0:0] c;
		logic [7:0] b;
		bit         typed;
		beat_t      res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic        cmd;
	logic [7:0]  in_byte;
	logic        out_valid, out_ready;
	logic [7:0]  out_byte;
	logic [2:0]  status;
	logic        last_of_string;

	lzw_variable_width_decoder_unit #(.MAX_CODE_BITS(MAXB)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .in_byte(in_byte),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.status(status), .last_of_string(last_of_string)
	);

	always #1 clk = ~clk;

	// Decoder state mirror.
	logic [4:0]  lim_reg;
	logic [11:0] pfx_mem [SZ];
	logic [7:0]  sfx_mem [SZ];
	logic [7:0]  stk_mem [SZ];
	int          depth, bcnt, cw, nfc, prv;
	logic [31:0] bbuf;
	bit          pvalid, err;
	logic [7:0]  pfirst;

	// Stream encoder shadow.
	int          enc_nf, enc_w, n_codes;
	bit          enc_pv;
	logic [63:0] acc;
	int          acc_n;
	logic [7:0]  stream_q[$];
	int          dir_codes[$];

	beat_t       decoded_q[$];
	int          fails = 0;
	bit          quiet = 0;
	int          stall = 0;

	function automatic int eff_lim();
		int l;
		l = lim_reg;
		if (l > MAXB) l = MAXB;
		if (l < START_WIDTH) l = START_WIDTH;
		return l;
	endfunction

	function automatic void stack_byte(logic [7:0] b);
		if (depth < SZ) begin
			stk_mem[depth] = b;
			depth++;
		end
	endfunction

	function automatic logic [2:0] expand_code(int c);
		int lim, x, steps, e;
		logic [7:0] first;
		lim = eff_lim();
		if (c == CLEAR_CODE) begin
			cw = START_WIDTH;
			nfc = FIRST_FREE;
			pvalid = 0;
			return ST_ACCEPTED;
		end
		if (c > nfc || (c == nfc && !pvalid)) begin
			err = 1;
			return ST_ERROR;
		end
		if (c == nfc) begin
			stack_byte(pfirst);
			x = prv;
		end else begin
			x = c;
		end
		x &= SZ - 1;
		steps = 0;
		while (x >= CLEAR_CODE && steps < SZ) begin
			stack_byte(sfx_mem[x]);
			x = pfx_mem[x];
			steps++;
		end
		first = x[7:0];
		stack_byte(first);
		if (pvalid && nfc < (1 << lim)) begin
			e = nfc & (SZ - 1);
			pfx_mem[e] = prv[11:0];
			sfx_mem[e] = first;
			nfc++;
		end
		if (cw < lim && nfc >= (1 << cw)) cw++;
		prv = c & (SZ - 1);
		pfirst = first;
		pvalid = 1;
		return ST_ACCEPTED;
	endfunction

	function automatic beat_t decode_step(logic [0:0] c, logic [7:0] b);
		beat_t r;
		int code;
		r = '0;
		if (c == CMD_PULL) begin
			if (depth > 0) begin
				depth--;
				r.ob = stk_mem[depth];
				r.last = (depth == 0);
				r.st = ST_BYTE;
			end else begin
				r.st = err ? ST_ERROR : ST_EMPTY;
			end
		end else if (err) begin
			r.st = ST_ERROR;
		end else if (depth > 0) begin
			r.st = ST_BUSY;
		end else begin
			bbuf |= 32'(b) << bcnt;
			bcnt += 8;
			r.st = ST_ACCEPTED;
			if (bcnt >= cw) begin
				code = bbuf & ((1 << cw) - 1);
				bbuf = (bbuf >> cw) & 32'hFFFFFF;
				bcnt -= cw;
				r.st = expand_code(code);
			end
		end
		return r;
	endfunction

	// Packs a code LSB first at the width the decoder will be using for it.
	function automatic void emit_code(int c);
		int lim;
		lim = eff_lim();
		acc |= 64'(c) << acc_n;
		acc_n += enc_w;
		while (acc_n >= 8) begin
			stream_q.push_back(acc[7:0]);
			acc >>= 8;
			acc_n -= 8;
		end
		if (c == CLEAR_CODE) begin
			enc_w = START_WIDTH;
			enc_nf = FIRST_FREE;
			enc_pv = 0;
		end else begin
			if (enc_pv && enc_nf < (1 << lim)) enc_nf++;
			if (enc_w < lim && enc_nf >= (1 << enc_w)) enc_w++;
			enc_pv = 1;
		end
		n_codes++;
	endfunction

	function automatic int pick_code();
		int r;
		if (dir_codes.size() > 0) return dir_codes.pop_front();
		r = $urandom_range(0, 99);
		if (r < 3 && enc_pv) return CLEAR_CODE;
		if (r < 12 && enc_pv && enc_nf < (1 << enc_w)) return enc_nf;
		if (r < 60 || enc_nf <= FIRST_FREE) return $urandom_range(0, 255);
		return $urandom_range(FIRST_FREE, enc_nf - 1);
	endfunction

	task automatic send(logic [0:0] c, logic [7:0] b, bit typed, beat_t res);
		beat_t r;
		cmd <= c;
		in_byte <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = decode_step(c, b);
		decoded_q.push_back(typed ? res : r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic next_item();
		if (depth > 0) begin
			if ($urandom_range(0, 9) == 0) send(CMD_PUSH, 8'($urandom), 0, '0);
			else send(CMD_PULL, 8'($urandom), 0, '0);
		end else if ($urandom_range(0, 19) == 0) begin
			send(CMD_PULL, 8'($urandom), 0, '0);
		end else begin
			if (stream_q.size() == 0) emit_code(pick_code());
			if (stream_q.size() > 0) send(CMD_PUSH, stream_q.pop_front(), 0, '0);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (decoded_q.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [4:0] v);
		wait_drained();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= LIMIT_ADDR;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		lim_reg = v;
		@(posedge clk);
	endtask

	task automatic run_phase(logic [4:0] limit, int ncodes, bit clear);
		write_limit(limit);
		n_codes = 0;
		if (clear) emit_code(CLEAR_CODE);
		// Ends on a byte boundary so that a later limit change cannot skew widths.
		while (n_codes < ncodes || acc_n != 0 || stream_q.size() > 0 || depth > 0)
			next_item();
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result beat: status %0d", status);
					fails++;
				end else begin
					e = decoded_q.pop_front();
					if (out_byte !== e.ob) begin
						$error("out_byte: expected %0h, got %0h", e.ob, out_byte);
						fails++;
					end
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						fails++;
					end
					if (last_of_string !== e.last) begin
						$error("last_of_string: expected %0d, got %0d", e.last, last_of_string);
						fails++;
					end
				end
			end
			if (stall > 0) begin
				stall <= stall - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall <= $urandom_range(0, 14);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5ms;
		$display("** lzw_variable_width_decoder_unit: FAILED **");
		$finish;
	end

	initial begin
		row_t head_rows[$];
		row_t tail_rows[$];
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_PUSH;
		in_byte <= '0;
		lim_reg = 5'd12;
		depth = 0; bcnt = 0; bbuf = '0; cw = START_WIDTH; nfc = FIRST_FREE;
		prv = 0; pvalid = 0; pfirst = '0; err = 0;
		enc_nf = FIRST_FREE; enc_w = START_WIDTH; enc_pv = 0; acc = '0; acc_n = 0;
		head_rows = '{
			'{CMD_PULL, 8'h00, 1, '{8'h00, ST_EMPTY, 1'b0}},
			'{CMD_PULL, 8'hFF, 1, '{8'h00, ST_EMPTY, 1'b0}}
		};
		// Past the clear code the stream sits at nine bits with few entries, so
		// an all-ones code lies beyond the next free code.
		tail_rows = '{
			'{CMD_PUSH, 8'hFF, 1, '{8'h00, ST_ACCEPTED, 1'b0}},
			'{CMD_PUSH, 8'hFF, 1, '{8'h00, ST_ERROR, 1'b0}},
			'{CMD_PUSH, 8'h00, 1, '{8'h00, ST_ERROR, 1'b0}},
			'{CMD_PULL, 8'h00, 1, '{8'h00, ST_ERROR, 1'b0}},
			'{CMD_PUSH, 8'h5A, 1, '{8'h00, ST_ERROR, 1'b0}}
		};
		// Literals, new entries, a KwKwK code, a clear, then reuse after it.
		dir_codes = '{65, 66, 257, 259, 256, 0, 255, 257, 258, 260};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (head_rows[i])
			send(head_rows[i].c, head_rows[i].b, head_rows[i].typed, head_rows[i].res);
		run_phase(5'd12, 20, 0);
		run_phase(5'd9, 100, 1);
		run_phase(5'd10, 50, 0);
		run_phase(5'd0, 20, 1);
		run_phase(5'd31, 25, 1);
		quiet = 1;
		run_phase(5'd16, 35, 1);
		foreach (tail_rows[i])
			send(tail_rows[i].c, tail_rows[i].b, tail_rows[i].typed, tail_rows[i].res);
		wait_drained();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("** lzw_variable_width_decoder_unit: PASSED **");
		else
			$display("** lzw_variable_width_decoder_unit: FAILED **");
		$finish;
	end

endmodule
